>>> hdl/gcm_pkg.sv
// Package for the greedy change maker: field widths, register indexes,
// line kinds and the sequencer state type. No dependencies.
package gcm_pkg;

    localparam int AMT_W   = 31;  // amount, denomination and count width
    localparam int IDX_W   = 3;   // denomination index and register index width
    localparam int CNT_W   = 5;   // divider step counter width

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_DENOM_COUNT = 3'd0;
    localparam logic [IDX_W-1:0] REG_DENOM_FIRST = 3'd1;

    // line kinds
    localparam logic KIND_COIN  = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SELECT,
        ST_DIV,
        ST_EMIT,
        ST_FINAL
    } state_t;

endpackage

>>> hdl/greedy_change_maker.sv
// Greedy change maker top level: sequencer around one shared restoring divider.
// Depends on gcm_pkg.
//
// The block takes one amount and splits it greedily over up to MAX_DENOMS
// denominations, used in register order (write them largest first). For every
// denomination in use that fits the remaining amount it sends one coin line;
// then it sends a final line with the leftover and last set. Zero
// denominations, and those larger than the remainder, are skipped. Each
// division runs on a single restoring divider, one quotient bit per cycle.
// in_stall is high from the accepted amount until its final line is loaded
// into the output register; the next amount may enter while that final
// line still waits to be taken.
module greedy_change_maker #(
    parameter int MAX_DENOMS = 7
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration write port
    input  logic                       cfg_we,
    input  logic [gcm_pkg::IDX_W-1:0]  cfg_index,
    input  logic [gcm_pkg::AMT_W-1:0]  cfg_data,
    // input channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [gcm_pkg::AMT_W-1:0]  amount,
    // output channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       entry_kind,
    output logic [gcm_pkg::IDX_W-1:0]  denom_index,
    output logic [gcm_pkg::AMT_W-1:0]  denomination,
    output logic [gcm_pkg::AMT_W-1:0]  coin_count,
    output logic [gcm_pkg::AMT_W-1:0]  leftover,
    output logic                       last
);

    import gcm_pkg::*;

    localparam int SEL_W = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
    localparam int DEPTH = 1 << SEL_W;

    // configuration
    logic [IDX_W-1:0] denom_count_reg;
    logic [AMT_W-1:0] denom_reg [DEPTH];

    // sequencer and divider
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [AMT_W-1:0] rem_reg, rem_next;
    logic [AMT_W-1:0] part_reg, part_next;
    logic [AMT_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] step_reg, step_next;

    // output word
    logic             out_valid_reg, out_valid_next;
    logic             out_kind_reg, out_kind_next;
    logic [IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [AMT_W-1:0] out_denom_reg, out_denom_next;
    logic [AMT_W-1:0] out_coins_reg, out_coins_next;
    logic [AMT_W-1:0] out_left_reg, out_left_next;
    logic             out_last_reg, out_last_next;

    logic             in_take;
    logic             out_free;
    logic [AMT_W-1:0] d_sel;
    logic [AMT_W:0]   shifted;
    logic [AMT_W:0]   diff;
    logic             fits;
    logic [IDX_W-1:0] cnt_sat;

    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign d_sel    = denom_reg[idx_reg[SEL_W-1:0]];
    assign cnt_sat  = (denom_count_reg > IDX_W'(MAX_DENOMS)) ? IDX_W'(MAX_DENOMS)
                                                             : denom_count_reg;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    assign shifted = {part_reg, quo_reg[AMT_W-1]};
    assign diff    = shifted - {1'b0, d_sel};
    assign fits    = shifted >= {1'b0, d_sel};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            denom_count_reg <= '0;
            for (int i = 0; i < DEPTH; i++)
            begin
                denom_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_DENOM_COUNT)
            begin
                denom_count_reg <= cfg_data[IDX_W-1:0];
            end
            else if ((cfg_index - REG_DENOM_FIRST) < IDX_W'(MAX_DENOMS))
            begin
                denom_reg[SEL_W'(cfg_index - REG_DENOM_FIRST)] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        part_reg      <= part_next;
        quo_reg       <= quo_next;
        out_kind_reg  <= out_kind_next;
        out_idx_reg   <= out_idx_next;
        out_denom_reg <= out_denom_next;
        out_coins_reg <= out_coins_next;
        out_left_reg  <= out_left_next;
        out_last_reg  <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        part_next      = part_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_kind_next  = out_kind_reg;
        out_idx_next   = out_idx_reg;
        out_denom_next = out_denom_reg;
        out_coins_next = out_coins_reg;
        out_left_next  = out_left_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    rem_next   = amount;
                    idx_next   = '0;
                    cnt_next   = cnt_sat;
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                if (idx_reg == cnt_reg)
                begin
                    state_next = ST_FINAL;
                end
                else if (d_sel == '0 || rem_reg < d_sel)
                begin
                    // zero quotient or unused slot: no line
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    part_next  = '0;
                    quo_next   = rem_reg;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                part_next = fits ? diff[AMT_W-1:0] : shifted[AMT_W-1:0];
                quo_next  = {quo_reg[AMT_W-2:0], fits};
                step_next = step_reg + 1'b1;
                if (step_reg == CNT_W'(AMT_W - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_COIN;
                    out_idx_next   = idx_reg;
                    out_denom_next = d_sel;
                    out_coins_next = quo_reg;
                    out_left_next  = '0;
                    out_last_next  = 1'b0;
                    rem_next       = part_reg;
                    idx_next       = idx_reg + 1'b1;
                    state_next     = ST_SELECT;
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_FINAL;
                    out_idx_next   = '0;
                    out_denom_next = '0;
                    out_coins_next = '0;
                    out_left_next  = rem_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign entry_kind   = out_kind_reg;
    assign denom_index  = out_idx_reg;
    assign denomination = out_denom_reg;
    assign coin_count   = out_coins_reg;
    assign leftover     = out_left_reg;
    assign last         = out_last_reg;

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (d_sel != '0 && part_reg < d_sel))
        else $error("divider running with bad divisor or remainder");

    a_coin_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (out_coins_reg != '0 && out_left_reg == '0))
        else $error("coin line with zero count or nonzero leftover");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == ST_SELECT && idx_reg == '0))
        else $error("accepted amount did not start the run");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (idx_reg <= cnt_reg && cnt_reg <= IDX_W'(MAX_DENOMS)))
        else $error("denomination index beyond count");

    a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_last_reg == (out_kind_reg == KIND_FINAL)))
        else $error("last flag disagrees with line kind");

endmodule
